// File: hdl/wall_following_steering_controller_defines.svh
// Assertion macros shared by the checker of the steering controller.
// No dependencies.
`ifndef WALL_FOLLOWING_STEERING_CONTROLLER_DEFINES_SVH
`define WALL_FOLLOWING_STEERING_CONTROLLER_DEFINES_SVH
// Implication that is checked on every rising clock edge outside reset.
`define WFS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define WFS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// File: hdl/wfsc_pkg.sv
// Package of the wall following steering controller: constants, types, register indices.
// No dependencies.
package wfsc_pkg;
	localparam int unsigned SamplesPerUpdate = 16;
	localparam int unsigned CntW = $clog2(SamplesPerUpdate);
	localparam int unsigned SumW = 16 + CntW;

	localparam logic [2:0] REG_PROP  = 3'd0;
	localparam logic [2:0] REG_INTEG = 3'd1;
	localparam logic [2:0] REG_DERIV = 3'd2;
	localparam logic [2:0] REG_SCALE = 3'd3;
	localparam logic [2:0] REG_MARGIN = 3'd4;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quotient;
	} div_rsp_t;
endpackage

// File: hdl/wfsc_stream_if.sv
// Valid/ready channel interfaces of the steering controller.
// Depends on nothing.
interface wfsc_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] front_right_mm;
	logic [15:0] front_left_mm;
	logic [15:0] center_mm;
	logic [15:0] side_right_mm;
	logic [15:0] side_left_mm;
	logic [31:0] now_ms;
	modport source (output valid, front_right_mm, front_left_mm, center_mm,
		side_right_mm, side_left_mm, now_ms, input ready);
	modport sink (input valid, front_right_mm, front_left_mm, center_mm,
		side_right_mm, side_left_mm, now_ms, output ready);
endinterface

interface wfsc_out_if;
	logic        valid;
	logic        ready;
	logic [11:0] steer_cmd;
	logic signed [11:0] diff_cmd;
	logic [15:0] speed_cmd;
	modport source (output valid, steer_cmd, diff_cmd, speed_cmd, input ready);
	modport sink (input valid, steer_cmd, diff_cmd, speed_cmd, output ready);
endinterface

// File: hdl/wfsc_divider.sv
// Signed 32-bit restoring divider, one quotient bit per cycle, truncating.
// Depends on wfsc_pkg.
module wfsc_divider
	import wfsc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [31:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] den_q;
	logic        neg_q;
	logic        zero_q;
	logic        done_q;
	logic [31:0] quo_res;
	logic [32:0] trial;
	logic [31:0] a_abs, b_abs;

	assign a_abs = req.dividend[31] ? (32'd0 - req.dividend) : req.dividend;
	assign b_abs = req.divisor[31] ? (32'd0 - req.divisor) : req.divisor;
	assign trial = {rem_q[31:0], quo_q[31]} - {1'b0, den_q};
	assign rsp = {done_q, quo_res};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= a_abs;
			rem_q <= '0;
			den_q <= b_abs;
			neg_q <= req.dividend[31] ^ req.divisor[31];
			zero_q <= (req.divisor == 32'd0);
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[31:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (zero_q) quo_res = '0;
		else if (neg_q) quo_res = 32'd0 - quo_q;
		else quo_res = quo_q;
	end
endmodule

// File: hdl/wall_following_steering_controller.sv
// Wall following steering controller: accumulates 16 items, then updates once.
// Non-final items are taken one per cycle while no result waits for transfer. The
// final item of a group starts an update that runs six divides on the shared
// divider in PID mode and none in corner mode, then raises the result valid.
// Input is held off from the final item until its result transfer.
// Reset clears counts, sums, PID state and restores register defaults.
module wall_following_steering_controller
	import wfsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	wfsc_in_if.sink     in_ch,
	wfsc_out_if.source  out_ch
);
	// The sequencer walks through the steps below; every division by a variable
	// goes through the single shared divider, the fixed divisions of the linear
	// maps reduce to a multiply and a shift, and one multiply runs per step with a
	// register after each.
	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_SETUP = 10'b0000000010,
		ST_MUL   = 10'b0000000100,
		ST_DIV   = 10'b0000001000,
		ST_WAIT  = 10'b0000010000,
		ST_POST  = 10'b0000100000,
		ST_CLAMP = 10'b0001000000,
		ST_OUT   = 10'b0010000000,
		ST_SPARE1 = 10'b0100000000,
		ST_SPARE2 = 10'b1000000000
	} state_t;

	state_t state_q;
	logic [3:0] step_q;
	logic signed [15:0] kp_q, ki_q, kd_q;
	logic [15:0] scale_q, margin_q;
	logic [CntW-1:0] count_q;
	logic [SumW-1:0] sum_q [5];
	logic signed [31:0] integ_q, lerr_q, ltime_q;
	logic signed [31:0] avg_q [5];
	logic signed [31:0] dt_q, sc_q, err_q, acc_q, tmp_q, p_q, steer_q, diff_q, speed_q;
	logic signed [31:0] mul_a, mul_b, mul_r, div_a, div_b;
	logic signed [31:0] cdiv_r;
	div_req_t dreq;
	div_rsp_t drsp;
	logic [11:0] steer_o_q, diff_o_q;
	logic [15:0] speed_o_q;
	logic        ovalid_q;
	logic        acc_in;

	wfsc_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign acc_in = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE) && !ovalid_q;
	assign out_ch.valid = ovalid_q;
	assign out_ch.steer_cmd = steer_o_q;
	assign out_ch.diff_cmd = diff_o_q;
	assign out_ch.speed_cmd = speed_o_q;
	assign mul_r = mul_a * mul_b;

	// Fixed divisions: 1000/400 and 3000/400 become times 5 and 15 halved toward
	// zero, and 6000/8000 becomes times 3 shifted by two (the center is never negative).
	assign cdiv_r = (step_q == 4'd8) ? (mul_r >>> 2) :
		($signed(mul_r + {31'd0, mul_r[31]}) >>> 1);

	// Step plan. Corner: 0 steer, 1 diff, 8 speed, each without the divider.
	// PID: 2 p, 3 integral increment, 4 i, 5 to 7 derivative (two divides, then kd),
	// then 8 speed.
	always_comb begin
		mul_a = '0; mul_b = '0; div_a = tmp_q; div_b = sc_q;
		case (step_q)
			4'd0: begin mul_a = acc_q; mul_b = 32'sd5; end
			4'd1: begin mul_a = acc_q; mul_b = 32'sd15; end
			4'd2: begin mul_a = 32'(kp_q); mul_b = err_q; end
			4'd3: begin mul_a = err_q; mul_b = dt_q; end
			4'd4: begin mul_a = 32'(ki_q); mul_b = integ_q; end
			4'd5: begin mul_a = err_q - lerr_q; mul_b = 32'sd1; div_b = dt_q; end
			4'd6: begin mul_a = tmp_q; mul_b = 32'sd1; end
			4'd7: begin mul_a = 32'(kd_q); mul_b = tmp_q; end
			4'd8: begin mul_a = avg_q[2]; mul_b = 32'sd3; end
			default: ;
		endcase
	end

	assign dreq.start = (state_q == ST_DIV);
	assign dreq.dividend = div_a;
	assign dreq.divisor = div_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			kp_q <= 16'sd50; ki_q <= 16'sd0; kd_q <= 16'sd200;
			scale_q <= 16'd100; margin_q <= 16'd1000;
			count_q <= '0;
			for (int k = 0; k < 5; k++) sum_q[k] <= '0;
			integ_q <= '0; lerr_q <= '0; ltime_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PROP:   kp_q <= cfg_data;
					REG_INTEG:  ki_q <= cfg_data;
					REG_DERIV:  kd_q <= cfg_data;
					REG_SCALE:  scale_q <= cfg_data;
					REG_MARGIN: margin_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (acc_in) begin
						if (count_q == CntW'(SamplesPerUpdate - 1)) begin
							count_q <= '0;
							avg_q[0] <= 32'(({16'd0, sum_q[0]} + in_ch.front_right_mm) >> 4);
							avg_q[1] <= 32'(({16'd0, sum_q[1]} + in_ch.front_left_mm) >> 4);
							avg_q[2] <= 32'(({16'd0, sum_q[2]} + in_ch.center_mm) >> 4);
							avg_q[3] <= 32'(({16'd0, sum_q[3]} + in_ch.side_right_mm) >> 4);
							avg_q[4] <= 32'(({16'd0, sum_q[4]} + in_ch.side_left_mm) >> 4);
							for (int k = 0; k < 5; k++) sum_q[k] <= '0;
							dt_q <= (in_ch.now_ms - ltime_q == 32'd0) ? 32'sd1 :
								in_ch.now_ms - ltime_q;
							ltime_q <= in_ch.now_ms;
							sc_q <= (scale_q == 16'd0) ? 32'sd1 : {16'd0, scale_q};
							state_q <= ST_SETUP;
						end else begin
							count_q <= count_q + 1'b1;
							sum_q[0] <= sum_q[0] + in_ch.front_right_mm;
							sum_q[1] <= sum_q[1] + in_ch.front_left_mm;
							sum_q[2] <= sum_q[2] + in_ch.center_mm;
							sum_q[3] <= sum_q[3] + in_ch.side_right_mm;
							sum_q[4] <= sum_q[4] + in_ch.side_left_mm;
						end
					end
				end
				ST_SETUP: begin
					// Offset front difference for the linear maps (x - in_lo).
					acc_q <= avg_q[0] - avg_q[1] + 32'sd200;
					err_q <= avg_q[3] - avg_q[4];
					if (avg_q[2] < {16'd0, margin_q}) begin
						step_q <= 4'd0; integ_q <= '0;
					end else step_q <= 4'd2;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (step_q inside {4'd0, 4'd1, 4'd8}) begin
						tmp_q <= cdiv_r;
						state_q <= ST_POST;
					end else begin
						tmp_q <= mul_r;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: state_q <= ST_WAIT;
				ST_WAIT: if (drsp.done) begin
					tmp_q <= drsp.quotient;
					state_q <= ST_POST;
				end
				ST_POST: begin
					state_q <= (step_q >= 4'd8) ? ST_CLAMP : ST_MUL;
					case (step_q)
						4'd0: begin steer_q <= tmp_q + 32'sd2450; step_q <= 4'd1; end
						4'd1: begin diff_q <= tmp_q - 32'sd1500; step_q <= 4'd8; end
						4'd2: begin p_q <= tmp_q; step_q <= 4'd3; end
						4'd3: begin integ_q <= integ_q + tmp_q; step_q <= 4'd4; end
						4'd4: begin p_q <= p_q + tmp_q; step_q <= 4'd5; end
						4'd5: step_q <= 4'd6;
						4'd6: step_q <= 4'd7;
						4'd7: begin
							steer_q <= 32'sd2900 + p_q + tmp_q;
							diff_q <= p_q + tmp_q;
							lerr_q <= err_q;
							step_q <= 4'd8;
						end
						4'd8: speed_q <= tmp_q + 32'sd4000;
						default: ;
					endcase
				end
				ST_CLAMP: begin
					steer_o_q <= (steer_q < 32'sd2450) ? 12'd2450 :
						(steer_q > 32'sd3450) ? 12'd3450 : steer_q[11:0];
					diff_o_q <= (diff_q < -32'sd1500) ? 12'(-1500) :
						(diff_q > 32'sd1500) ? 12'd1500 : diff_q[11:0];
					speed_o_q <= speed_q[15:0];
					state_q <= ST_OUT;
				end
				ST_OUT: begin ovalid_q <= 1'b1; state_q <= ST_IDLE; end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: hdl/wfsc_checker.sv
// Port-level checker of the steering controller, bound to the top level.
// Depends on wall_following_steering_controller_defines.svh.
`include "wall_following_steering_controller_defines.svh"
module wfsc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [11:0] steer_cmd,
	input logic [11:0] diff_cmd
);
	`WFS_ASSERT_IMP(a_steer_range, out_valid, steer_cmd >= 12'd2450 && steer_cmd <= 12'd3450)
	`WFS_ASSERT_IMP(a_diff_range, out_valid, $signed(diff_cmd) >= -12'sd1500 && $signed(diff_cmd) <= 12'sd1500)
	`WFS_ASSERT_IMP(a_no_take_while_out, out_valid, !in_ready)
	`WFS_ASSERT_NXT(a_out_holds, out_valid && !out_ready, out_valid && $stable(steer_cmd))
	`WFS_ASSERT_NXT(a_in_holds, in_valid && !in_ready, in_valid)
endmodule

bind wall_following_steering_controller wfsc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.steer_cmd(out_ch.steer_cmd), .diff_cmd(out_ch.diff_cmd)
);

// File: dv/wall_following_steering_controller_tb.sv
// Self-checking testbench of the wall following steering controller.
// Depends on wfsc_pkg, wfsc_stream_if and the controller RTL.
`timescale 1ns / 1ps

module wall_following_steering_controller_tb;
	import wfsc_pkg::*;

	localparam int CycleLimit = 600000;
	// Covers the update that the last item of a group starts, with margin.
	localparam int SettleCycles = 450;
	localparam int IdlePercent = 21;

	typedef struct {
		logic [15:0] front_right;
		logic [15:0] front_left;
		logic [15:0] center;
		logic [15:0] side_right;
		logic [15:0] side_left;
		logic [31:0] stamp;
	} sample_t;

	typedef struct {
		logic [11:0] steer;
		logic [11:0] diff;
		logic [15:0] speed;
	} drive_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = REG_PROP;
	logic [15:0] cfg_data = '0;

	wfsc_in_if in_ch ();
	wfsc_out_if out_ch ();

	wall_following_steering_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	// Expected drive commands, oldest first.
	drive_cmd_t expected_cmds[$];

	// Shadow of the controller's registers and state.
	int m_prop, m_integ, m_deriv;
	int unsigned m_scale, m_margin;
	int unsigned grp_count;
	int unsigned sensor_sum[5];
	int integ_acc, prev_err;
	logic [31:0] prev_stamp;

	int errors = 0;
	int cycles = 0;
	int n_items = 0;
	int n_cmds = 0;
	int n_corner = 0;
	int n_pid = 0;
	bit quiet = 1'b0;        // when set, neither side idles
	int stall_left = 0;      // cycles that the receiver still holds off
	logic [31:0] clock_ms = '0;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("FAIL wall_following_steering_controller");
			$finish;
		end
	end

	// Truncating division; a zero divisor gives zero and the one overflowing
	// quotient wraps back to the most negative value.
	function automatic int trunc_div(int a, int b);
		if (b == 0)
			return 0;
		if (a == 32'sh8000_0000 && b == -1)
			return a;
		return a / b;
	endfunction

	function automatic int lin_map(int x, int in_lo, int in_hi, int out_lo, int out_hi);
		return trunc_div((x - in_lo) * (out_hi - out_lo), in_hi - in_lo) + out_lo;
	endfunction

	function automatic int clamp(int v, int lo, int hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	task automatic reset_model();
		m_prop = 50;
		m_integ = 0;
		m_deriv = 200;
		m_scale = 100;
		m_margin = 1000;
		grp_count = 0;
		foreach (sensor_sum[k])
			sensor_sum[k] = 0;
		integ_acc = 0;
		prev_err = 0;
		prev_stamp = '0;
	endtask

	// Accumulates one sample and, on the last sample of a group, works out the
	// steering, differential and speed commands that the block must produce.
	task automatic predict_steering(sample_t s);
		int avg[5];
		int dt, sc, fe, err, p, i_term, der, d, pid, steer, diff, speed;
		drive_cmd_t c;
		sensor_sum[0] += s.front_right;
		sensor_sum[1] += s.front_left;
		sensor_sum[2] += s.center;
		sensor_sum[3] += s.side_right;
		sensor_sum[4] += s.side_left;
		grp_count++;
		if (grp_count < SamplesPerUpdate)
			return;
		grp_count = 0;
		foreach (avg[k]) begin
			avg[k] = int'(sensor_sum[k] >> 4);
			sensor_sum[k] = 0;
		end
		// The time step is a signed difference; only zero is replaced.
		dt = int'(s.stamp - prev_stamp);
		if (dt == 0)
			dt = 1;
		prev_stamp = s.stamp;
		sc = (m_scale == 0) ? 1 : int'(m_scale);
		if (avg[2] < int'(m_margin)) begin
			// Corner mode: map the front difference and forget the integral.
			fe = avg[0] - avg[1];
			steer = lin_map(fe, -200, 200, 2450, 3450);
			diff = lin_map(fe, -200, 200, -1500, 1500);
			integ_acc = 0;
			n_corner++;
		end else begin
			err = 0 - (avg[4] - avg[3]);
			p = trunc_div(m_prop * err, sc);
			integ_acc = integ_acc + trunc_div(err * dt, sc);
			i_term = trunc_div(m_integ * integ_acc, sc);
			der = trunc_div(trunc_div(err - prev_err, dt), sc);
			d = trunc_div(m_deriv * der, sc);
			prev_err = err;
			pid = p + i_term + d;
			steer = 2900 + pid;
			diff = pid;
			n_pid++;
		end
		steer = clamp(steer, 2450, 3450);
		diff = clamp(diff, -1500, 1500);
		speed = lin_map(avg[2], 0, 8000, 4000, 10000);
		c.steer = steer[11:0];
		c.diff = diff[11:0];
		c.speed = speed[15:0];
		expected_cmds.push_back(c);
	endtask

	// Offers one sample and waits for its transfer. Called at a rising edge.
	// Valid stays high from one item to the next unless an idle gap is drawn.
	task automatic send_sample(sample_t s);
		while (!quiet && $urandom_range(99) < IdlePercent) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.front_right_mm <= s.front_right;
		in_ch.front_left_mm <= s.front_left;
		in_ch.center_mm <= s.center;
		in_ch.side_right_mm <= s.side_right;
		in_ch.side_left_mm <= s.side_left;
		in_ch.now_ms <= s.stamp;
		do
			@(posedge clk);
		while (!in_ch.ready);
		predict_steering(s);
		n_items++;
	endtask

	// Lets every expected command arrive, then waits out any work still running.
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		wait (expected_cmds.size() == 0);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Writes all five registers on consecutive edges; only called when idle.
	task automatic set_regs(logic [15:0] p, logic [15:0] i, logic [15:0] d,
			logic [15:0] sc, logic [15:0] mg);
		logic [15:0] vals[5];
		logic [2:0] idx[5];
		vals = '{p, i, d, sc, mg};
		idx = '{REG_PROP, REG_INTEG, REG_DERIV, REG_SCALE, REG_MARGIN};
		foreach (vals[k]) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[k];
			cfg_data <= vals[k];
			@(posedge clk);
			case (idx[k])
				REG_PROP: m_prop = $signed(vals[k]);
				REG_INTEG: m_integ = $signed(vals[k]);
				REG_DERIV: m_deriv = $signed(vals[k]);
				REG_SCALE: m_scale = vals[k];
				default: m_margin = vals[k];
			endcase
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// One distance sample near a nominal value, now and then any 16-bit value
	// so that every bit of every field gets exercised.
	function automatic logic [15:0] near(int nominal, int spread);
		int v;
		if ($urandom_range(99) < 8)
			return 16'($urandom);
		v = nominal + $urandom_range(2 * spread) - spread;
		return 16'(clamp(v, 0, 65535));
	endfunction

	// A whole group with random content. The time stamp of the last sample
	// moves forward mostly, but sometimes stays, steps back or jumps anywhere.
	task automatic random_group();
		sample_t s;
		int ctr, fr, sl, sr, pick;
		pick = $urandom_range(99);
		ctr = (pick < 40) ? $urandom_range(m_margin > 0 ? m_margin : 1)
			: $urandom_range(65535);
		fr = $urandom_range(65535);
		sl = $urandom_range(65535);
		sr = sl + $urandom_range(600) - 300;
		for (int k = 0; k < SamplesPerUpdate; k++) begin
			s.front_right = near(fr, 250);
			s.front_left = near(fr, 250);
			s.center = near(ctr, 100);
			s.side_right = near(sr, 100);
			s.side_left = near(sl, 100);
			case ($urandom_range(9))
				0: clock_ms = clock_ms;
				1: clock_ms = clock_ms - $urandom_range(500);
				2: clock_ms = $urandom;
				default: clock_ms = clock_ms + $urandom_range(20);
			endcase
			s.stamp = clock_ms;
			send_sample(s);
		end
	endtask

	// Result checker: compares each transfer with the oldest expectation.
	always @(posedge clk) begin
		drive_cmd_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			n_cmds <= n_cmds + 1;
			if (expected_cmds.size() == 0) begin
				$display("%0t: unexpected command steer=%0d diff=%0d speed=%0d", $time,
					out_ch.steer_cmd, out_ch.diff_cmd, out_ch.speed_cmd);
				errors = errors + 1;
			end else begin
				e = expected_cmds.pop_front();
				if (out_ch.steer_cmd !== e.steer) begin
					$display("%0t: steer_cmd expected %0d actual %0d", $time,
						e.steer, out_ch.steer_cmd);
					errors = errors + 1;
				end
				if (out_ch.diff_cmd !== e.diff) begin
					$display("%0t: diff_cmd expected %0d actual %0d", $time,
						$signed(e.diff), out_ch.diff_cmd);
					errors = errors + 1;
				end
				if (out_ch.speed_cmd !== e.speed) begin
					$display("%0t: speed_cmd expected %0d actual %0d", $time,
						e.speed, out_ch.speed_cmd);
					errors = errors + 1;
				end
			end
		end
	end

	// Receiver: random back-pressure, none during quiet stretches, and a long
	// hold-off whenever stall_left has been loaded.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			out_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (quiet) begin
			out_ch.ready <= 1'b1;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= IdlePercent);
		end
	end

	// Both corners of the sample space: all-zero samples give corner mode with
	// a centered front, saturated samples give PID mode and the top speed.
	task automatic test_field_extremes();
		sample_t s;
		for (int k = 0; k < SamplesPerUpdate; k++) begin
			s = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0};
			send_sample(s);
		end
		for (int k = 0; k < SamplesPerUpdate; k++) begin
			s = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF};
			send_sample(s);
		end
		drain();
	endtask

	// Zero gain scale is read as one; the time stamp repeats (zero time step)
	// and then wraps around past zero, with a strong steer either way.
	task automatic test_special_cases();
		sample_t s;
		set_regs(16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000);
		for (int g = 0; g < 3; g++) begin
			for (int k = 0; k < SamplesPerUpdate; k++) begin
				s.front_right = 16'd500;
				s.front_left = 16'd800;
				s.center = 16'd3000;
				s.side_right = (g == 1) ? 16'hFFFF : 16'd0;
				s.side_left = (g == 1) ? 16'd0 : 16'hFFFF;
				s.stamp = (g == 2) ? 32'h0000_0100 : 32'hFFFF_FFFF;
				send_sample(s);
			end
		end
		drain();
		// Corner mode at the far ends of the front difference.
		set_regs(16'd50, 16'd0, 16'd200, 16'hFFFF, 16'hFFFF);
		for (int g = 0; g < 2; g++) begin
			for (int k = 0; k < SamplesPerUpdate; k++) begin
				s = '{(g == 0) ? 16'hFFFF : 16'd0, (g == 0) ? 16'd0 : 16'hFFFF,
					16'd100, 16'd10, 16'd20, 32'd5 + g};
				send_sample(s);
			end
		end
		drain();
	endtask

	// Random groups under a run of settings, extremes included, plus a few
	// stray samples that shift the group boundaries.
	task automatic test_random_settings();
		logic [15:0] cfgs[8][5];
		cfgs = '{
			'{16'd50, 16'd0, 16'd200, 16'd100, 16'd1000},
			'{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd1, 16'd65535},
			'{16'h8000, 16'h8000, 16'h8000, 16'd1, 16'd0},
			'{16'd300, 16'd20, 16'h8000, 16'hFFFF, 16'd2000},
			'{16'hFFFF, 16'd1, 16'd1, 16'd0, 16'd30000},
			'{16'd0, 16'd0, 16'd0, 16'd7, 16'd500},
			'{16'd120, 16'd40, 16'd900, 16'd50, 16'd8000},
			'{16'd0, 16'd0, 16'd0, 16'd0, 16'd0}};
		foreach (cfgs[c]) begin
			for (int r = 0; r < 5; r++)
				if ($urandom_range(3) == 0 && c > 0 && c < 7)
					cfgs[c][r] = 16'($urandom);
			set_regs(cfgs[c][0], cfgs[c][1], cfgs[c][2], cfgs[c][3], cfgs[c][4]);
			// A stretch without idling on either side in the middle phase.
			quiet = (c == 3);
			for (int g = 0; g < 7; g++)
				random_group();
			quiet = 1'b0;
			if (c == 5)
				for (int k = 0; k < 3; k++)
					send_sample('{16'($urandom), 16'($urandom), 16'($urandom),
						16'($urandom), 16'($urandom), $urandom});
			drain();
		end
	endtask

	// The receiver holds off for a long time while samples keep coming, so the
	// block backs up and stalls its input; then the sender waits for all results.
	task automatic test_backpressure();
		stall_left <= 3000;
		for (int g = 0; g < 4; g++)
			random_group();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		wait (expected_cmds.size() == 0);
		@(posedge clk);
		for (int g = 0; g < 3; g++)
			random_group();
		drain();
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.front_right_mm = '0;
		in_ch.front_left_mm = '0;
		in_ch.center_mm = '0;
		in_ch.side_right_mm = '0;
		in_ch.side_left_mm = '0;
		in_ch.now_ms = '0;
		reset_model();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_special_cases();
		test_random_settings();
		test_backpressure();

		$display("Sent %0d samples, checked %0d commands (%0d corner, %0d PID).",
			n_items, n_cmds, n_corner, n_pid);
		if (errors == 0 && expected_cmds.size() == 0) begin
			$display("PASS wall_following_steering_controller");
		end else begin
			$display("%0d mismatches, %0d commands missing", errors, expected_cmds.size());
			$display("FAIL wall_following_steering_controller");
		end
		$finish;
	end
endmodule
